[hdl/jsu_pkg.sv]
// Package for the JSON string unescape decoder: result kinds, result and
// group types, queue depth default. No dependencies.
`timescale 1ns / 1ps

package jsu_pkg;

    localparam logic [1:0] KIND_BYTE = 2'd0;
    localparam logic [1:0] KIND_DONE = 2'd1;
    localparam logic [1:0] KIND_BAD  = 2'd2;

    localparam int MAX_RESULTS = 4;
    localparam int FIFO_DEPTH  = 4;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] kind;
    } t_result;

    // results caused by one input transaction; cnt is 1 to 4
    typedef struct packed {
        logic [2:0]                     cnt;
        t_result [MAX_RESULTS-1:0]      res;
    } t_group;

endpackage

[hdl/jsu_in_if.sv]
// Input channel of the unescape decoder: raw byte and end-of-text mark.
// No dependencies.
`timescale 1ns / 1ps

interface jsu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_text;

    modport source (output valid, output in_byte, output end_of_text, input ready);
    modport sink   (input valid, input in_byte, input end_of_text, output ready);
endinterface

[hdl/jsu_out_if.sv]
// Output channel of the unescape decoder: decoded byte, kind and last flag.
// No dependencies.
`timescale 1ns / 1ps

interface jsu_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [1:0] kind;
    logic       last;

    modport source (output valid, output out_byte, output kind, output last, input ready);
    modport sink   (input valid, input out_byte, input kind, input last, output ready);
endinterface

[hdl/json_string_unescape_decoder_top.sv]
// JSON string unescape decoder, top level: front end, group queue, back end.
// Each group is registered in the queue and offered after earlier groups drain.
// Throughput: one input byte per cycle; each queued group drains one result per
// cycle while ready, so multi-result bytes stall input once four groups wait.
// Reset: synchronous active low; parser waits for an opening quote, queue empty.
// Depends on jsu_pkg, jsu_in_if, jsu_out_if, jsu_front, jsu_fifo, jsu_back.
`timescale 1ns / 1ps

module json_string_unescape_decoder_top import jsu_pkg::*; #(
    parameter int P_FIFO_DEPTH = FIFO_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    jsu_in_if.sink    i_in,
    jsu_out_if.source o_out
);

    logic   full, empty, push, pop, accept;
    t_group grp, head;

    assign i_in.ready = !full;
    assign accept     = i_in.valid && !full;

    jsu_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (i_in.in_byte),
        .i_eot    (i_in.end_of_text),
        .o_push   (push),
        .o_group  (grp)
    );

    jsu_fifo #(.DEPTH(P_FIFO_DEPTH)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (grp),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (head)
    );

    jsu_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_head  (head),
        .i_ready (o_out.ready),
        .o_valid (o_out.valid),
        .o_byte  (o_out.out_byte),
        .o_kind  (o_out.kind),
        .o_last  (o_out.last),
        .o_pop   (pop)
    );

endmodule

[hdl/jsu_front.sv]
// Front end: parser state and classification of each input byte into a
// group of up to four results. Depends on jsu_pkg.
`timescale 1ns / 1ps

module jsu_front import jsu_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_byte,
    input  logic       i_eot,
    output logic       o_push,
    output t_group     o_group
);

    typedef enum logic [4:0] {
        PH_OPEN = 5'b00001,
        PH_BODY = 5'b00010,
        PH_ESC  = 5'b00100,
        PH_HEX  = 5'b01000,
        PH_WAIT = 5'b10000
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [1:0]  r_hex, n_hex;
    logic [15:0] r_cp, n_cp;

    function automatic logic [4:0] hex_value(input logic [7:0] b);
        if (b >= 8'h30 && b <= 8'h39) return {1'b0, 4'(b - 8'h30)};
        if (b >= 8'h61 && b <= 8'h66) return {1'b0, 4'(b - 8'h57)};
        if (b >= 8'h41 && b <= 8'h46) return {1'b0, 4'(b - 8'h37)};
        return 5'h10;
    endfunction

    logic [2:0]  n;
    logic [4:0]  v;
    logic [15:0] cp;
    t_group      grp;

    always_comb begin
        n_phase = r_phase;
        n_hex   = r_hex;
        n_cp    = r_cp;
        grp     = '0;
        n       = 3'd0;
        v       = hex_value(i_byte);
        cp      = {r_cp[11:0], v[3:0]};
        unique case (r_phase)
            PH_OPEN: begin
                if (i_byte == 8'h22) begin
                    n_phase = PH_BODY;
                    n_hex   = 2'd0;
                    n_cp    = 16'd0;
                end else begin
                    grp.res[n[1:0]] = '{8'h00, KIND_BAD};
                    n = n + 3'd1;
                    n_phase = PH_WAIT;
                end
            end
            PH_BODY: begin
                if (i_byte == 8'h22) begin
                    grp.res[n[1:0]] = '{8'h00, KIND_DONE};
                    n = n + 3'd1;
                    n_phase = PH_WAIT;
                end else if (i_byte == 8'h5c) begin
                    n_phase = PH_ESC;
                end else begin
                    grp.res[n[1:0]] = '{i_byte, KIND_BYTE};
                    n = n + 3'd1;
                end
            end
            PH_ESC: begin
                n_phase = PH_BODY;
                unique case (i_byte)
                    8'h22, 8'h5c, 8'h2f: begin
                        grp.res[n[1:0]] = '{i_byte, KIND_BYTE};
                        n = n + 3'd1;
                    end
                    8'h62: begin
                        grp.res[n[1:0]] = '{8'h08, KIND_BYTE};
                        n = n + 3'd1;
                    end
                    8'h66: begin
                        grp.res[n[1:0]] = '{8'h0c, KIND_BYTE};
                        n = n + 3'd1;
                    end
                    8'h6e: begin
                        grp.res[n[1:0]] = '{8'h0a, KIND_BYTE};
                        n = n + 3'd1;
                    end
                    8'h72: begin
                        grp.res[n[1:0]] = '{8'h0d, KIND_BYTE};
                        n = n + 3'd1;
                    end
                    8'h74: begin
                        grp.res[n[1:0]] = '{8'h09, KIND_BYTE};
                        n = n + 3'd1;
                    end
                    8'h75: begin
                        n_phase = PH_HEX;
                        n_hex   = 2'd0;
                        n_cp    = 16'd0;
                    end
                    default: begin
                        grp.res[n[1:0]] = '{8'h00, KIND_BAD};
                        n = n + 3'd1;
                        n_phase = PH_WAIT;
                    end
                endcase
            end
            PH_HEX: begin
                if (v[4]) begin
                    grp.res[n[1:0]] = '{8'h00, KIND_BAD};
                    n = n + 3'd1;
                    n_phase = PH_WAIT;
                end else begin
                    n_cp = cp;
                    if (r_hex == 2'd3) begin
                        if (cp < 16'h0080) begin
                            grp.res[0] = '{cp[7:0], KIND_BYTE};
                            n = 3'd1;
                        end else if (cp < 16'h0800) begin
                            grp.res[0] = '{{3'b110, cp[10:6]}, KIND_BYTE};
                            grp.res[1] = '{{2'b10, cp[5:0]}, KIND_BYTE};
                            n = 3'd2;
                        end else begin
                            grp.res[0] = '{{4'b1110, cp[15:12]}, KIND_BYTE};
                            grp.res[1] = '{{2'b10, cp[11:6]}, KIND_BYTE};
                            grp.res[2] = '{{2'b10, cp[5:0]}, KIND_BYTE};
                            n = 3'd3;
                        end
                        n_hex   = 2'd0;
                        n_phase = PH_BODY;
                    end else begin
                        n_hex = r_hex + 2'd1;
                    end
                end
            end
            default: ;
        endcase

        if (i_eot) begin
            if (n_phase == PH_BODY || n_phase == PH_ESC || n_phase == PH_HEX) begin
                grp.res[n[1:0]] = '{8'h00, KIND_BAD};
                n = n + 3'd1;
            end
            n_phase = PH_OPEN;
            n_hex   = 2'd0;
            n_cp    = 16'd0;
        end
        grp.cnt = n;
    end

    assign o_push  = i_accept && (n != 3'd0);
    assign o_group = grp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_OPEN;
            r_hex   <= 2'd0;
            r_cp    <= 16'd0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_hex   <= n_hex;
            r_cp    <= n_cp;
        end
    end

endmodule

[hdl/jsu_fifo.sv]
// Result group queue between front and back end, register storage with
// combinational head. Depends on jsu_pkg.
`timescale 1ns / 1ps

module jsu_fifo import jsu_pkg::*; #(
    parameter int DEPTH = FIFO_DEPTH
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_group i_data,
    input  logic   i_pop,
    output logic   o_full,
    output logic   o_empty,
    output t_group o_head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_group        r_mem [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;
    logic          do_push, do_pop;

    assign o_full  = (r_cnt == FULL_CNT);
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == LAST_PTR) ? '0 : r_wr + PW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == LAST_PTR) ? '0 : r_rd + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule

[hdl/jsu_back.sv]
// Back end: serializes the head result group into one result per
// transaction and marks the last one. Depends on jsu_pkg.
`timescale 1ns / 1ps

module jsu_back import jsu_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_empty,
    input  t_group     i_head,
    input  logic       i_ready,
    output logic       o_valid,
    output logic [7:0] o_byte,
    output logic [1:0] o_kind,
    output logic       o_last,
    output logic       o_pop
);

    logic [1:0] r_idx;
    logic [2:0] cnt_m1;
    logic       fire;

    assign cnt_m1  = i_head.cnt - 3'd1;
    assign o_valid = !i_empty;
    assign o_byte  = i_head.res[r_idx].out_byte;
    assign o_kind  = i_head.res[r_idx].kind;
    assign o_last  = (r_idx == cnt_m1[1:0]);
    assign fire    = o_valid && i_ready;
    assign o_pop   = fire && o_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= 2'd0;
        end else if (fire) begin
            r_idx <= o_last ? 2'd0 : r_idx + 2'd1;
        end
    end

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// Testbench for json_string_unescape_decoder_top: a directed byte table, then random JSON
// texts, checked against table expectations or an in-bench decoder model. Depends on
// jsu_pkg, jsu_in_if, jsu_out_if and the decoder RTL.

module testbench;
    import jsu_pkg::*;

    typedef enum logic [2:0] {ST_OPEN, ST_BODY, ST_ESC, ST_HEX, ST_DROP} t_parse;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] kind;
        logic       last;
    } t_decoded;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       eot;
        logic       typed;
        logic [2:0] cnt;
        logic [7:0] exp_byte;
        logic [1:0] exp_kind;
    } t_row;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_U      = 8'h75;

    localparam int DIR_N       = 24;
    localparam int RAND_ITEMS  = 270;
    localparam int STALL_LIMIT = 2000;
    localparam int TAIL_CYCLES = 10;

    localparam logic [7:0] ESC_CHARS [8] = '{8'h22, 8'h5c, 8'h2f, 8'h62, 8'h66, 8'h6e,
                                              8'h72, 8'h74};
    localparam logic [15:0] CP_BOUNDS [8] = '{16'h0000, 16'h007f, 16'h0080, 16'h07ff,
                                               16'h0800, 16'hffff, 16'hd800, 16'hdfff};

    // typed rows carry their own expectation, the rest go through the decoder model
    localparam t_row DIR_TAB [DIR_N] = '{
        '{8'h41, 1'b0, 1'b1, 3'd1, 8'h00, KIND_BAD},
        '{8'h00, 1'b1, 1'b1, 3'd0, 8'h00, KIND_BYTE},
        '{8'h22, 1'b0, 1'b1, 3'd0, 8'h00, KIND_BYTE},
        '{8'h00, 1'b0, 1'b1, 3'd1, 8'h00, KIND_BYTE},
        '{8'hff, 1'b0, 1'b1, 3'd1, 8'hff, KIND_BYTE},
        '{8'h5c, 1'b0, 1'b0, 3'd0, 8'h00, KIND_BYTE},
        '{8'h6e, 1'b0, 1'b0, 3'd0, 8'h00, KIND_BYTE},
        '{8'h5c, 1'b0, 1'b0, 3'd0, 8'h00, KIND_BYTE},
        '{8'h75, 1'b0, 1'b0, 3'd0, 8'h00, KIND_BYTE},
        '{8'h46, 1'b0, 1'b0, 3'd0, 8'h00, KIND_BYTE},
        '{8'h66, 1'b0, 1'b0, 3'd0, 8'h00, KIND_BYTE},
        '{8'h66, 1'b0, 1'b0, 3'd0, 8'h00, KIND_BYTE},
        '{8'h46, 1'b0, 1'b0, 3'd0, 8'h00, KIND_BYTE},
        '{8'h5c, 1'b0, 1'b0, 3'd0, 8'h00, KIND_BYTE},
        '{8'h71, 1'b0, 1'b1, 3'd1, 8'h00, KIND_BAD},
        '{8'h78, 1'b1, 1'b1, 3'd0, 8'h00, KIND_BYTE},
        '{8'h22, 1'b0, 1'b1, 3'd0, 8'h00, KIND_BYTE},
        '{8'h5c, 1'b0, 1'b1, 3'd0, 8'h00, KIND_BYTE},
        '{8'h75, 1'b0, 1'b1, 3'd0, 8'h00, KIND_BYTE},
        '{8'h47, 1'b1, 1'b1, 3'd1, 8'h00, KIND_BAD},
        '{8'h22, 1'b1, 1'b1, 3'd1, 8'h00, KIND_BAD},
        '{8'h22, 1'b0, 1'b1, 3'd0, 8'h00, KIND_BYTE},
        '{8'h22, 1'b0, 1'b1, 3'd1, 8'h00, KIND_DONE},
        '{8'h7f, 1'b1, 1'b1, 3'd0, 8'h00, KIND_BYTE}
    };

    logic i_clk;
    logic i_rst_n = 1'b0;

    jsu_in_if  in_if ();
    jsu_out_if out_if ();

    json_string_unescape_decoder_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    t_parse      dec_phase   = ST_OPEN;
    logic [1:0]  dec_hex_cnt = '0;
    logic [15:0] dec_cp      = '0;

    t_decoded   decoded_burst [$];
    t_decoded   expected_q    [$];
    t_row       plan_q        [$];
    logic [7:0] text_q        [$];

    int mismatch_cnt = 0;
    int checked_cnt  = 0;
    int done_cnt     = 0;
    int bad_cnt      = 0;
    int live_cnt     = 0;
    int sent_cnt     = 0;
    int text_cnt     = 0;
    int idle_cycles  = 0;
    bit tx_burst     = 1'b0;
    bit rx_burst     = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic void emit(input logic [7:0] b, input logic [1:0] k);
        t_decoded d;
        d = '{b, k, 1'b0};
        decoded_burst.insert(decoded_burst.size(), d);
    endfunction

    function automatic void decode_step(input logic [7:0] b, input logic eot);
        logic [4:0]  nib;
        logic [15:0] cp;
        decoded_burst.delete();
        case (dec_phase)
            ST_OPEN: begin
                if (b == CH_QUOTE) begin
                    dec_phase   = ST_BODY;
                    dec_hex_cnt = '0;
                    dec_cp      = '0;
                end else begin
                    emit(8'h00, KIND_BAD);
                    dec_phase = ST_DROP;
                end
            end
            ST_BODY: begin
                if (b == CH_QUOTE) begin
                    emit(8'h00, KIND_DONE);
                    dec_phase = ST_DROP;
                end else if (b == CH_BSLASH) begin
                    dec_phase = ST_ESC;
                end else begin
                    emit(b, KIND_BYTE);
                end
            end
            ST_ESC: begin
                dec_phase = ST_BODY;
                case (b)
                    8'h22, 8'h5c, 8'h2f: emit(b, KIND_BYTE);
                    8'h62: emit(8'h08, KIND_BYTE);
                    8'h66: emit(8'h0c, KIND_BYTE);
                    8'h6e: emit(8'h0a, KIND_BYTE);
                    8'h72: emit(8'h0d, KIND_BYTE);
                    8'h74: emit(8'h09, KIND_BYTE);
                    CH_U: begin
                        dec_phase   = ST_HEX;
                        dec_hex_cnt = '0;
                        dec_cp      = '0;
                    end
                    default: begin
                        emit(8'h00, KIND_BAD);
                        dec_phase = ST_DROP;
                    end
                endcase
            end
            ST_HEX: begin
                if (b >= 8'h30 && b <= 8'h39)
                    nib = {1'b0, b[3:0]};
                else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46))
                    nib = {1'b0, b[3:0]} + 5'd9;
                else
                    nib = 5'd16;
                if (nib[4]) begin
                    emit(8'h00, KIND_BAD);
                    dec_phase = ST_DROP;
                end else begin
                    cp     = {dec_cp[11:0], nib[3:0]};
                    dec_cp = cp;
                    if (dec_hex_cnt == 2'd3) begin
                        if (cp < 16'h0080) begin
                            emit(cp[7:0], KIND_BYTE);
                        end else if (cp < 16'h0800) begin
                            emit({3'b110, cp[10:6]}, KIND_BYTE);
                            emit({2'b10, cp[5:0]}, KIND_BYTE);
                        end else begin
                            emit({4'b1110, cp[15:12]}, KIND_BYTE);
                            emit({2'b10, cp[11:6]}, KIND_BYTE);
                            emit({2'b10, cp[5:0]}, KIND_BYTE);
                        end
                        dec_hex_cnt = '0;
                        dec_phase   = ST_BODY;
                    end else begin
                        dec_hex_cnt = dec_hex_cnt + 2'd1;
                    end
                end
            end
            default: ;
        endcase
        if (eot) begin
            if (dec_phase == ST_BODY || dec_phase == ST_ESC || dec_phase == ST_HEX)
                emit(8'h00, KIND_BAD);
            dec_phase   = ST_OPEN;
            dec_hex_cnt = '0;
            dec_cp      = '0;
        end
        if (decoded_burst.size() > 0)
            decoded_burst[decoded_burst.size() - 1].last = 1'b1;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        if (nib < 4'd10)
            return 8'h30 + {4'b0, nib};
        return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + {4'b0, nib} - 8'd10;
    endfunction

    function automatic void push_hex(input logic [15:0] cp, input int ndig);
        for (int k = 0; k < ndig; k++)
            text_q.insert(text_q.size(), hex_char(cp[15 - 4 * k -: 4]));
    endfunction

    function automatic void push_token();
        logic [7:0]  b;
        logic [15:0] cp;
        case ($urandom_range(0, 3))
            0, 1: begin
                do b = 8'($urandom_range(0, 255)); while (b == CH_QUOTE || b == CH_BSLASH);
                text_q.insert(text_q.size(), b);
            end
            2: begin
                text_q.insert(text_q.size(), CH_BSLASH);
                text_q.insert(text_q.size(), ESC_CHARS[$urandom_range(0, 7)]);
            end
            default: begin
                case ($urandom_range(0, 3))
                    0:       cp = 16'($urandom_range(0, 16'h007f));
                    1:       cp = 16'($urandom_range(16'h0080, 16'h07ff));
                    2:       cp = 16'($urandom_range(16'h0800, 16'hffff));
                    default: cp = CP_BOUNDS[$urandom_range(0, 7)];
                endcase
                text_q.insert(text_q.size(), CH_BSLASH);
                text_q.insert(text_q.size(), CH_U);
                push_hex(cp, 4);
            end
        endcase
    endfunction

    task automatic send_byte(input t_row row);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        plan_q.insert(plan_q.size(), row);
        in_if.valid       <= 1'b1;
        in_if.in_byte     <= row.in_byte;
        in_if.end_of_text <= row.eot;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        sent_cnt++;
    endtask

    task automatic send_text(input bit noisy);
        logic eot;
        for (int k = 0; k < text_q.size(); k++) begin
            eot = (k == text_q.size() - 1) || (noisy && $urandom_range(0, 3) == 0);
            send_byte('{text_q[k], eot, 1'b0, 3'd0, 8'h00, KIND_BYTE});
        end
        text_cnt++;
    endtask

    task automatic drain_results();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (expected_q.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        int         sel;
        int         live_base;
        bit         junk;
        logic [7:0] b;
        in_if.valid       <= 1'b0;
        in_if.in_byte     <= 8'h00;
        in_if.end_of_text <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int k = 0; k < DIR_N; k++)
            send_byte(DIR_TAB[k]);
        drain_results();

        live_base = live_cnt;
        while (live_cnt - live_base < RAND_ITEMS) begin
            if (text_cnt % 8 == 7)
                drain_results();
            tx_burst = ($urandom_range(0, 3) == 0);
            sel      = $urandom_range(0, 9);
            junk     = 1'b1;
            text_q.delete();
            if (sel == 9) begin
                repeat ($urandom_range(1, 5))
                    text_q.insert(text_q.size(), 8'($urandom_range(0, 255)));
                junk = 1'b0;
            end else begin
                text_q.insert(text_q.size(), CH_QUOTE);
                repeat ($urandom_range(0, 6)) push_token();
                if (sel < 7) begin
                    text_q.insert(text_q.size(), CH_QUOTE);
                end else begin
                    case ($urandom_range(0, 2))
                        0: begin
                            do b = 8'($urandom_range(0, 255));
                            while (b inside {8'h22, 8'h5c, 8'h2f, 8'h62, 8'h66, 8'h6e,
                                             8'h72, 8'h74, CH_U});
                            text_q.insert(text_q.size(), CH_BSLASH);
                            text_q.insert(text_q.size(), b);
                        end
                        1: begin
                            do b = 8'($urandom_range(0, 255));
                            while ((b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h46)
                                   || (b >= 8'h61 && b <= 8'h66));
                            text_q.insert(text_q.size(), CH_BSLASH);
                            text_q.insert(text_q.size(), CH_U);
                            push_hex(16'($urandom_range(0, 16'hffff)), $urandom_range(0, 3));
                            text_q.insert(text_q.size(), b);
                        end
                        default: begin
                            // text ends while the string is still open
                            junk = 1'b0;
                            case ($urandom_range(0, 2))
                                0: ;
                                1: text_q.insert(text_q.size(), CH_BSLASH);
                                default: begin
                                    text_q.insert(text_q.size(), CH_BSLASH);
                                    text_q.insert(text_q.size(), CH_U);
                                    push_hex(16'($urandom_range(0, 16'hffff)),
                                             $urandom_range(0, 3));
                                end
                            endcase
                        end
                    endcase
                end
            end
            if (junk)
                repeat ($urandom_range(0, 2))
                    text_q.insert(text_q.size(), 8'($urandom_range(0, 255)));
            send_text(sel == 9);
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("Sent %0d bytes: %0d directed, then %0d random texts; %0d results checked.",
                 sent_cnt, DIR_N, text_cnt, checked_cnt);
        $display("Statuses seen: %0d complete, %0d malformed; %0d mismatches.",
                 done_cnt, bad_cnt, mismatch_cnt);
        if (mismatch_cnt == 0 && expected_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial begin
        int hold;
        out_if.ready <= 1'b0;
        @(posedge i_clk);
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            hold = rx_burst ? 0 : $urandom_range(0, 3);
            if (hold > 0) begin
                out_if.ready <= 1'b0;
                repeat (hold) @(posedge i_clk);
            end
            out_if.ready <= 1'b1;
            @(posedge i_clk);
            while (!out_if.valid) @(posedge i_clk);
            if ($urandom_range(0, 15) == 0)
                rx_burst = ~rx_burst;
        end
    end

    // output transactions are checked before the input transaction of the same edge is modeled
    always @(posedge i_clk) begin
        t_row     row;
        t_decoded got;
        t_decoded want;
        if (i_rst_n) begin
            if (out_if.valid && out_if.ready) begin
                got = '{out_if.out_byte, out_if.kind, out_if.last};
                checked_cnt++;
                if (got.kind == KIND_DONE)
                    done_cnt++;
                if (got.kind == KIND_BAD)
                    bad_cnt++;
                if (expected_q.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("%0t: unexpected result byte %h kind %0d last %b",
                                 $realtime, got.out_byte, got.kind, got.last);
                end else begin
                    want = expected_q.pop_front();
                    if (got.out_byte !== want.out_byte || got.kind !== want.kind
                        || got.last !== want.last) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10)
                            $display("%0t: expected %h/%0d/%b, got %h/%0d/%b",
                                     $realtime, want.out_byte, want.kind, want.last,
                                     got.out_byte, got.kind, got.last);
                    end
                end
            end
            if (in_if.valid && in_if.ready) begin
                row = plan_q.pop_front();
                if (dec_phase != ST_DROP)
                    live_cnt++;
                decode_step(in_if.in_byte, in_if.end_of_text);
                if (!row.typed) begin
                    foreach (decoded_burst[k])
                        expected_q.insert(expected_q.size(), decoded_burst[k]);
                end else if (row.cnt != 3'd0) begin
                    want = '{row.exp_byte, row.exp_kind, 1'b1};
                    expected_q.insert(expected_q.size(), want);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Watchdog: no transaction for %0d cycles", idle_cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

endmodule

[json_string_unescape_decoder_top.f]
hdl/jsu_pkg.sv
hdl/jsu_in_if.sv
hdl/jsu_out_if.sv
hdl/jsu_front.sv
hdl/jsu_fifo.sv
hdl/jsu_back.sv
hdl/json_string_unescape_decoder_top.sv
tb/testbench.sv
